FILE: rtl/core/tfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared constants, types and the font table of the text framebuffer renderer.
// ----------------------------------------------------------------------------
package tfr_pkg;

	localparam int SCREEN_WIDTH  = 84;
	localparam int SCREEN_HEIGHT = 48;
	localparam int GLYPH_WIDTH   = 5;
	localparam int CELL_WIDTH    = 7;

	localparam int PAGE_ROWS = SCREEN_HEIGHT / 8;
	localparam int BUF_BYTES = SCREEN_WIDTH * PAGE_ROWS;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int IDX_W     = 16;
	localparam int CNT_W     = 4;

	localparam logic [6:0]  FIRST_CODE = 7'h20;
	localparam logic [6:0]  DIGIT_BASE = 7'h10;
	localparam logic [6:0]  MAX_DIGIT  = 7'd9;
	localparam logic [15:0] BIT_PAIR   = 16'hC000;
	localparam logic [7:0]  BLANK      = 8'h00;

	localparam logic [2:0] REQ_CHAR    = 3'd0;
	localparam logic [2:0] REQ_DIGIT   = 3'd1;
	localparam logic [2:0] REQ_CLEAR   = 3'd2;
	localparam logic [2:0] REQ_REFRESH = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_POS  = 2'd1;
	localparam logic [1:0] ST_CODE = 2'd2;

	typedef struct packed {
		logic              draw_we;
		logic [ADDR_W-1:0] draw_waddr;
		logic [7:0]        draw_wdata;
		logic              draw_re;
		logic [ADDR_W-1:0] draw_raddr;
		logic              shown_we;
		logic [ADDR_W-1:0] shown_waddr;
		logic [7:0]        shown_wdata;
		logic              shown_re;
		logic [ADDR_W-1:0] shown_raddr;
	} mem_req_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [1:0] status;
	} res_t;

	// Glyph packed with column 0 in the top byte.
	function automatic logic [39:0] font_glyph(input logic [6:0] idx);
		logic [39:0] g;
		case (idx)
			7'd0:  g = 40'h0000000000;
			7'd1:  g = 40'h00005f0000;
			7'd2:  g = 40'h0007000700;
			7'd3:  g = 40'h147f147f14;
			7'd4:  g = 40'h242a7f2a12;
			7'd5:  g = 40'h2313086462;
			7'd6:  g = 40'h3649552250;
			7'd7:  g = 40'h0005030000;
			7'd8:  g = 40'h001c224100;
			7'd9:  g = 40'h0041221c00;
			7'd10: g = 40'h14083e0814;
			7'd11: g = 40'h08083e0808;
			7'd12: g = 40'h0050300000;
			7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0060600000;
			7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3e5149453e;
			7'd17: g = 40'h00427f4000;
			7'd18: g = 40'h4261514946;
			7'd19: g = 40'h2141454b31;
			7'd20: g = 40'h1814127f10;
			7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3c4a494930;
			7'd23: g = 40'h0171090503;
			7'd24: g = 40'h3649494936;
			7'd25: g = 40'h064949291e;
			7'd26: g = 40'h0036360000;
			7'd27: g = 40'h0056360000;
			7'd28: g = 40'h0814224100;
			7'd29: g = 40'h1414141414;
			7'd30: g = 40'h0041221408;
			7'd31: g = 40'h0201510906;
			7'd32: g = 40'h324979413e;
			7'd33: g = 40'h7e1111117e;
			7'd34: g = 40'h7f49494936;
			7'd35: g = 40'h3e41414122;
			7'd36: g = 40'h7f4141221c;
			7'd37: g = 40'h7f49494941;
			7'd38: g = 40'h7f09090901;
			7'd39: g = 40'h3e4149497a;
			7'd40: g = 40'h7f0808087f;
			7'd41: g = 40'h00417f4100;
			7'd42: g = 40'h2040413f01;
			7'd43: g = 40'h7f08142241;
			7'd44: g = 40'h7f40404040;
			7'd45: g = 40'h7f020c027f;
			7'd46: g = 40'h7f0408107f;
			7'd47: g = 40'h3e4141413e;
			7'd48: g = 40'h7f09090906;
			7'd49: g = 40'h3e4151215e;
			7'd50: g = 40'h7f09192946;
			7'd51: g = 40'h4649494931;
			7'd52: g = 40'h01017f0101;
			7'd53: g = 40'h3f4040403f;
			7'd54: g = 40'h1f2040201f;
			7'd55: g = 40'h3f4038403f;
			7'd56: g = 40'h6314081463;
			7'd57: g = 40'h0708700807;
			7'd58: g = 40'h6151494543;
			7'd59: g = 40'h007f414100;
			7'd60: g = 40'h0204081020;
			7'd61: g = 40'h0041417f00;
			7'd62: g = 40'h0402010204;
			7'd63: g = 40'h4040404040;
			7'd64: g = 40'h0001020400;
			7'd65: g = 40'h2054545478;
			7'd66: g = 40'h7f48444438;
			7'd67: g = 40'h3844444420;
			7'd68: g = 40'h384444487f;
			7'd69: g = 40'h3854545418;
			7'd70: g = 40'h087e090102;
			7'd71: g = 40'h0c5252523e;
			7'd72: g = 40'h7f08040478;
			7'd73: g = 40'h00447d4000;
			7'd74: g = 40'h2040443d00;
			7'd75: g = 40'h7f10284400;
			7'd76: g = 40'h00417f4000;
			7'd77: g = 40'h7c04180478;
			7'd78: g = 40'h7c08040478;
			7'd79: g = 40'h3844444438;
			7'd80: g = 40'h7c14141408;
			7'd81: g = 40'h081414187c;
			7'd82: g = 40'h7c08040408;
			7'd83: g = 40'h4854545420;
			7'd84: g = 40'h043f444020;
			7'd85: g = 40'h3c4040207c;
			7'd86: g = 40'h1c2040201c;
			7'd87: g = 40'h3c4030403c;
			7'd88: g = 40'h4428102844;
			7'd89: g = 40'h0c5050503c;
			7'd90: g = 40'h4464544c44;
			7'd91: g = 40'h0008364100;
			7'd92: g = 40'h00007f0000;
			7'd93: g = 40'h0041360800;
			7'd94: g = 40'h1008081008;
			7'd95: g = 40'h7846414678;
			default: g = 40'h0000000000;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] i);
		logic [7:0] b;
		case (i)
			3'd0:    b = g[39:32];
			3'd1:    b = g[31:24];
			3'd2:    b = g[23:16];
			3'd3:    b = g[15:8];
			3'd4:    b = g[7:0];
			default: b = BLANK;
		endcase
		return b;
	endfunction

	// Bit k of the column lands on bits 2k and 2k+1.
	function automatic logic [15:0] stretch_col(input logic [7:0] bits);
		logic [15:0] acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			acc = acc >> 2;
			if (bits[k]) begin
				acc = acc | BIT_PAIR;
			end
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tfr_bufs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_bufs
// Draw and shown frame buffers: one write and one registered read port each.
// ----------------------------------------------------------------------------
module tfr_bufs
	import tfr_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output logic [7:0]    draw_rdata,
	output logic [7:0]    shown_rdata
);

	logic [7:0] draw_mem  [BUF_BYTES];
	logic [7:0] shown_mem [BUF_BYTES];

	always_ff @(posedge clk) begin
		if (req.draw_we) begin
			draw_mem[req.draw_waddr] <= req.draw_wdata;
		end
		if (req.draw_re) begin
			draw_rdata <= draw_mem[req.draw_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.shown_we) begin
			shown_mem[req.shown_waddr] <= req.shown_wdata;
		end
		if (req.shown_re) begin
			shown_rdata <= shown_mem[req.shown_raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/tfr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_seq
// Request sequencer: range checks, cell byte generation, clear/copy sweeps.
// ----------------------------------------------------------------------------
module tfr_seq
	import tfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [2:0] req_type,
	input  wire logic [2:0] row,
	input  wire logic [3:0] col,
	input  wire logic [6:0] code,
	input  wire logic [8:0] read_index,
	input  wire logic [7:0] draw_rdata,
	input  wire logic [7:0] shown_rdata,
	input  wire logic       res_take,
	output logic            idle,
	output mem_req_t        mem_req,
	output res_t            res
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHAR   = 4'd2;
	localparam logic [3:0] S_DIGIT  = 4'd3;
	localparam logic [3:0] S_CLEAR  = 4'd4;
	localparam logic [3:0] S_COPY   = 4'd5;
	localparam logic [3:0] S_RDWAIT = 4'd6;
	localparam logic [3:0] S_FINISH = 4'd7;

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(BUF_BYTES - 1);
	localparam logic [CNT_W-1:0]  CHAR_LAST  = CNT_W'(CELL_WIDTH - 1);
	localparam logic [CNT_W-1:0]  DIGIT_LAST = CNT_W'(2 * CELL_WIDTH - 1);

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              half_q;
	logic [39:0]       glyph_q;
	logic [7:0]        data_q;
	logic [1:0]        status_q;
	logic              copy_vld_s1;
	logic [ADDR_W-1:0] copy_addr_s1;

	// Request decode on the incoming fields
	logic [IDX_W-1:0] row_w, col_px, base_w;
	logic             char_pos_ok, digit_pos_ok, idx_ok;
	logic [6:0]       font_idx;

	assign row_w  = IDX_W'(row);
	assign col_px = IDX_W'(col) * IDX_W'(CELL_WIDTH);
	assign base_w = row_w * IDX_W'(SCREEN_WIDTH) + col_px;

	assign char_pos_ok  = (row_w < IDX_W'(PAGE_ROWS)) &&
	                      (col_px + IDX_W'(CELL_WIDTH) <= IDX_W'(SCREEN_WIDTH));
	assign digit_pos_ok = (row_w + IDX_W'(1) < IDX_W'(PAGE_ROWS)) &&
	                      (col_px + IDX_W'(2 * CELL_WIDTH) <= IDX_W'(SCREEN_WIDTH));
	assign idx_ok       = IDX_W'(read_index) < IDX_W'(BUF_BYTES);
	assign font_idx     = (req_type == REQ_CHAR) ? (code - FIRST_CODE) : (code + DIGIT_BASE);

	// Where an accepted request goes next; position is checked before code
	logic [3:0] dec_state;
	logic [1:0] dec_status;
	logic       dec_sweep;

	always_comb begin
		dec_state  = S_FINISH;
		dec_status = ST_OK;
		dec_sweep  = 1'b0;
		unique case (req_type)
			REQ_CHAR: begin
				if (!char_pos_ok) begin
					dec_status = ST_POS;
				end else if (code < FIRST_CODE) begin
					dec_status = ST_CODE;
				end else begin
					dec_state = S_CHAR;
				end
			end
			REQ_DIGIT: begin
				if (!digit_pos_ok) begin
					dec_status = ST_POS;
				end else if (code > MAX_DIGIT) begin
					dec_status = ST_CODE;
				end else begin
					dec_state = S_DIGIT;
				end
			end
			REQ_CLEAR: begin
				dec_sweep = 1'b1;
				dec_state = S_CLEAR;
			end
			REQ_REFRESH: begin
				dec_sweep = 1'b1;
				dec_state = S_COPY;
			end
			REQ_READ: begin
				if (idx_ok) begin
					dec_state = S_RDWAIT;
				end else begin
					dec_status = ST_POS;
				end
			end
			default: begin
			end
		endcase
	end

	// Cell byte generation
	logic [7:0]  char_byte, digit_byte, digit_col;
	logic [15:0] digit_tall;
	logic [CNT_W-1:0] dj;

	always_comb begin
		if (cnt_q == '0 || cnt_q == CHAR_LAST) begin
			char_byte = BLANK;
		end else begin
			char_byte = glyph_col(glyph_q, 3'(cnt_q - CNT_W'(1)));
		end
	end

	assign dj         = cnt_q - CNT_W'(2);
	assign digit_col  = glyph_col(glyph_q, dj[3:1]);
	assign digit_tall = stretch_col(digit_col);

	always_comb begin
		if (cnt_q < CNT_W'(2) || cnt_q > CNT_W'(2 * CELL_WIDTH - 3)) begin
			digit_byte = BLANK;
		end else begin
			digit_byte = half_q ? digit_tall[15:8] : digit_tall[7:0];
		end
	end

	assign idle = (state_q == S_IDLE);

	always_comb begin
		mem_req             = '0;
		mem_req.draw_waddr  = addr_q;
		mem_req.draw_raddr  = addr_q;
		mem_req.shown_waddr = copy_vld_s1 ? copy_addr_s1 : addr_q;
		mem_req.shown_wdata = copy_vld_s1 ? draw_rdata : BLANK;
		mem_req.shown_we    = copy_vld_s1 || (state_q == S_INIT);
		mem_req.shown_raddr = read_index[ADDR_W-1:0];
		mem_req.shown_re    = in_fire && (req_type == REQ_READ) && idx_ok;
		unique case (state_q) inside
			S_INIT, S_CLEAR: begin
				mem_req.draw_we    = 1'b1;
				mem_req.draw_wdata = BLANK;
			end
			S_CHAR: begin
				mem_req.draw_we    = 1'b1;
				mem_req.draw_wdata = char_byte;
			end
			S_DIGIT: begin
				mem_req.draw_we    = 1'b1;
				mem_req.draw_wdata = digit_byte;
			end
			S_COPY: begin
				mem_req.draw_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.valid  = (state_q == S_FINISH);
	assign res.data   = data_q;
	assign res.status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			addr_q      <= '0;
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1  <= (state_q == S_COPY);
			copy_addr_s1 <= addr_q;
			unique case (state_q) inside
				S_INIT: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						data_q   <= BLANK;
						status_q <= dec_status;
						addr_q   <= dec_sweep ? '0 : base_w[ADDR_W-1:0];
						base_q   <= base_w[ADDR_W-1:0];
						glyph_q  <= font_glyph(font_idx);
						cnt_q    <= '0;
						half_q   <= 1'b0;
						state_q  <= dec_state;
					end
				end
				S_CHAR: begin
					addr_q <= addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CHAR_LAST) begin
						state_q <= S_FINISH;
					end
				end
				S_DIGIT: begin
					if (cnt_q == DIGIT_LAST) begin
						// second half goes one page row down
						cnt_q  <= '0;
						half_q <= 1'b1;
						addr_q <= base_q + ADDR_W'(SCREEN_WIDTH);
						if (half_q) begin
							state_q <= S_FINISH;
						end
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
						cnt_q  <= cnt_q + CNT_W'(1);
					end
				end
				S_CLEAR, S_COPY: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (addr_q == LAST_ADDR) begin
						state_q <= S_FINISH;
					end
				end
				S_RDWAIT: begin
					data_q  <= shown_rdata;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/text_framebuffer_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_framebuffer_renderer_top
// Text renderer into a page-organized monochrome frame buffer pair.
// ----------------------------------------------------------------------------
// One request is worked at a time, each giving exactly one result. A character
// takes seven byte writes into the draw buffer, a big digit 28 writes, clear
// and refresh a sweep over all 504 bytes (refresh reading one buffer and
// writing the other each cycle), and a read one registered memory read; a
// rejected or unknown request goes straight to its result. After reset both
// buffers are zeroed by a pass over all bytes during which in_stall is high.
// Results sit in an output register, so a new request is taken while the
// previous result waits on out_stall.
module text_framebuffer_renderer_top
	import tfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] req_type,
	input  wire logic [2:0] row,
	input  wire logic [3:0] col,
	input  wire logic [6:0] code,
	input  wire logic [8:0] read_index,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data,
	output logic [1:0]      status
);

	mem_req_t   mem_req;
	res_t       res;
	logic       idle, in_fire, res_take;
	logic [7:0] draw_rdata, shown_rdata;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic [1:0] status_q;

	assign in_stall = !idle;
	assign in_fire  = in_valid && idle;
	assign res_take = !out_valid_q || !out_stall;

	tfr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.req_type   (req_type),
		.row        (row),
		.col        (col),
		.code       (code),
		.read_index (read_index),
		.draw_rdata (draw_rdata),
		.shown_rdata(shown_rdata),
		.res_take   (res_take),
		.idle       (idle),
		.mem_req    (mem_req),
		.res        (res)
	);

	tfr_bufs u_bufs (
		.clk        (clk),
		.req        (mem_req),
		.draw_rdata (draw_rdata),
		.shown_rdata(shown_rdata)
	);

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			read_data_q <= res.data;
			status_q    <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;

endmodule
`default_nettype wire

FILE: bench/text_framebuffer_renderer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_framebuffer_renderer_top_tb
// Self-checking bench for the text renderer: drives put-char, big-digit,
// clear, refresh, read and unused requests under random sender gaps and
// receiver stalls, and checks every result against a local frame buffer model.
// ----------------------------------------------------------------------------
module text_framebuffer_renderer_top_tb;
	import tfr_pkg::*;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] row;
		logic [3:0] col;
		logic [6:0] code;
		logic [8:0] idx;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [1:0] st;
	} reply_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	localparam int RANDOM_ITEMS = 1000;
	localparam int GLYPH_BITS   = 40;

	// 5x7 font, 0x20..0x7F; glyph 0 first, column 0 first within a glyph
	localparam logic [0:96*GLYPH_BITS-1] GLYPHS = {
		40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] req_type = '0;
	logic [2:0] row = '0;
	logic [3:0] col = '0;
	logic [6:0] code = '0;
	logic [8:0] read_index = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic [1:0] status;

	text_framebuffer_renderer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.row        (row),
		.col        (col),
		.code       (code),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.status     (status)
	);

	// local copy of both frame buffers
	logic [7:0] draw_mem  [BUF_BYTES];
	logic [7:0] shown_mem [BUF_BYTES];

	req_t        request_q[$];
	reply_t      predicted_replies[$];
	int unsigned planned_items;
	int unsigned queued_total;
	int unsigned accepted_total;
	int unsigned replies_checked;
	int unsigned err_cnt;
	int unsigned kind_seen [8];

	logic        in_taken = 1'b0;
	int unsigned gap_left;
	int unsigned burst_left;
	stall_mode_t stall_mode;
	int unsigned stall_run;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] glyph_byte(input int g, input int i);
		return GLYPHS[g*GLYPH_BITS + i*8 +: 8];
	endfunction

	// each bit of the column becomes two adjacent pixel rows
	function automatic logic [15:0] double_rows(input logic [7:0] b);
		logic [15:0] w;
		for (int k = 0; k < 8; k++) begin
			w[2*k]   = b[k];
			w[2*k+1] = b[k];
		end
		return w;
	endfunction

	function automatic void render_request(input req_t r);
		reply_t      rep;
		int          base;
		int          p;
		logic [15:0] tall;
		logic [7:0]  b;
		rep.kind = r.kind;
		rep.data = '0;
		rep.st   = ST_OK;
		base = r.row * SCREEN_WIDTH + r.col * CELL_WIDTH;
		case (r.kind)
			REQ_CHAR: begin
				if (r.row >= PAGE_ROWS || r.col * CELL_WIDTH + CELL_WIDTH > SCREEN_WIDTH) begin
					rep.st = ST_POS;
				end else if (r.code < FIRST_CODE) begin
					rep.st = ST_CODE;
				end else begin
					draw_mem[base] = BLANK;
					for (int i = 0; i < GLYPH_WIDTH; i++) begin
						draw_mem[base+1+i] = glyph_byte(r.code - FIRST_CODE, i);
					end
					draw_mem[base+1+GLYPH_WIDTH] = BLANK;
				end
			end
			REQ_DIGIT: begin
				if (r.row + 1 >= PAGE_ROWS ||
						r.col * CELL_WIDTH + 2 * CELL_WIDTH > SCREEN_WIDTH) begin
					rep.st = ST_POS;
				end else if (r.code > MAX_DIGIT) begin
					rep.st = ST_CODE;
				end else begin
					for (int h = 0; h < 2; h++) begin
						p = base + h * SCREEN_WIDTH;
						draw_mem[p]   = BLANK;
						draw_mem[p+1] = BLANK;
						for (int j = 0; j < GLYPH_WIDTH; j++) begin
							tall = double_rows(glyph_byte(DIGIT_BASE + r.code, j));
							b = (h != 0) ? tall[15:8] : tall[7:0];
							draw_mem[p+2+2*j] = b;
							draw_mem[p+3+2*j] = b;
						end
						draw_mem[p+12] = BLANK;
						draw_mem[p+13] = BLANK;
					end
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < BUF_BYTES; i++) draw_mem[i] = '0;
			end
			REQ_REFRESH: begin
				for (int i = 0; i < BUF_BYTES; i++) shown_mem[i] = draw_mem[i];
			end
			REQ_READ: begin
				if (r.idx < BUF_BYTES) rep.data = shown_mem[r.idx];
				else rep.st = ST_POS;
			end
			default: ;
		endcase
		predicted_replies.push_back(rep);
	endfunction

	function automatic req_t any_request();
		req_t r;
		r.kind = 3'($urandom_range(0, 7));
		r.row  = 3'($urandom());
		r.col  = 4'($urandom());
		r.code = 7'($urandom());
		r.idx  = 9'($urandom());
		return r;
	endfunction

	function automatic req_t mk(input logic [2:0] k, input int rw, input int cl,
			input int cd, input int ix);
		req_t r;
		r.kind = k;
		r.row  = 3'(rw);
		r.col  = 4'(cl);
		r.code = 7'(cd);
		r.idx  = 9'(ix);
		return r;
	endfunction

	function automatic void add(input req_t r);
		request_q.push_back(r);
		queued_total++;
		if (r.kind <= REQ_READ) planned_items++;
	endfunction

	// sender: bursts of random length, random gaps between them
	always @(negedge clk) begin
		req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled: payload held
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (request_q.size() != 0) begin
			nxt = request_q.pop_front();
			in_valid   <= 1'b1;
			req_type   <= nxt.kind;
			row        <= nxt.row;
			col        <= nxt.col;
			code       <= nxt.code;
			read_index <= nxt.idx;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall mode changes at random intervals
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_run  <= $urandom_range(20, 200);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 35);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
			default:     out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		reply_t want;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				render_request({req_type, row, col, code, read_index});
				kind_seen[req_type]++;
				accepted_total++;
			end
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result read_data=%02h status=%0d",
						$realtime, read_data, status);
				end else begin
					want = predicted_replies.pop_front();
					replies_checked++;
					if (read_data !== want.data) begin
						err_cnt++;
						$display("%0t: req %0d read_data expected %02h actual %02h",
							$realtime, want.kind, want.data, read_data);
					end
					if (status !== want.st) begin
						err_cnt++;
						$display("%0t: req %0d status expected %0d actual %0d",
							$realtime, want.kind, want.st, status);
					end
				end
			end
		end
	end

	initial begin
		req_t r;
		int   last_base;
		int   ix;
		for (int i = 0; i < BUF_BYTES; i++) begin
			draw_mem[i]  = '0;
			shown_mem[i] = '0;
		end

		// directed: field extremes, every request kind, each error case
		add(mk(REQ_CHAR, 0, 0, FIRST_CODE, 0));
		add(mk(REQ_CHAR, PAGE_ROWS - 1, 11, 7'h7f, 511));
		add(mk(REQ_CHAR, 2, 3, 7'h41, 0));
		add(mk(REQ_CHAR, 1, 1, FIRST_CODE - 1, 0));   // bad code
		add(mk(REQ_CHAR, PAGE_ROWS, 0, 7'h41, 0));     // row past bottom
		add(mk(REQ_CHAR, 0, 12, 7'h41, 0));            // cell past right edge
		add(mk(REQ_CHAR, 7, 15, 0, 0));                // both bad: position wins
		add(mk(REQ_DIGIT, 0, 0, 0, 0));
		add(mk(REQ_DIGIT, PAGE_ROWS - 2, 10, MAX_DIGIT, 0));
		add(mk(REQ_DIGIT, PAGE_ROWS - 1, 0, 1, 0));    // lower half off screen
		add(mk(REQ_DIGIT, 0, 11, 1, 0));               // right edge
		add(mk(REQ_DIGIT, 2, 2, MAX_DIGIT + 1, 0));    // not a digit
		add(mk(REQ_DIGIT, 7, 15, 127, 511));
		add(mk(REQ_REFRESH, 0, 0, 0, 0));
		add(mk(REQ_READ, 0, 0, 0, 0));
		add(mk(REQ_READ, 0, 0, 0, 1));
		add(mk(REQ_READ, 0, 0, 0, BUF_BYTES - 1));
		add(mk(REQ_READ, 0, 0, 0, BUF_BYTES));
		add(mk(REQ_READ, 7, 15, 127, 511));
		add(mk(REQ_READ + 3'd1, 7, 15, 127, 511));     // unused request kinds
		add(mk(REQ_READ + 3'd2, 0, 0, 0, 0));
		add(mk(REQ_READ + 3'd3, 5, 3, 7'h41, 100));
		add(mk(REQ_CLEAR, 0, 0, 0, 0));
		add(mk(REQ_READ, 0, 0, 0, SCREEN_WIDTH + 1));  // shown survives a clear
		add(mk(REQ_REFRESH, 0, 0, 0, 0));
		add(mk(REQ_READ, 0, 0, 0, 1));

		// random scenes: draw a few cells, usually refresh, read back around the last cell and elsewhere
		planned_items = 0;
		last_base = 0;
		while (planned_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) add(mk(REQ_CLEAR, $urandom(), $urandom(),
				$urandom(), $urandom()));
			repeat ($urandom_range(2, 10)) begin
				r = any_request();
				if ($urandom_range(0, 3) == 0) begin
					r.kind = REQ_DIGIT;
					if ($urandom_range(0, 9) != 0) r.row = 3'($urandom_range(0, PAGE_ROWS - 2));
					if ($urandom_range(0, 9) != 0) r.col = 4'($urandom_range(0, 10));
					if ($urandom_range(0, 9) != 0) r.code = 7'($urandom_range(0, MAX_DIGIT));
				end else begin
					r.kind = REQ_CHAR;
					if ($urandom_range(0, 9) != 0) r.row = 3'($urandom_range(0, PAGE_ROWS - 1));
					if ($urandom_range(0, 9) != 0) r.col = 4'($urandom_range(0, 11));
					if ($urandom_range(0, 9) != 0) r.code = 7'($urandom_range(FIRST_CODE, 127));
				end
				if (r.row * SCREEN_WIDTH + r.col * CELL_WIDTH < BUF_BYTES)
					last_base = r.row * SCREEN_WIDTH + r.col * CELL_WIDTH;
				// occasional noise: anything at all, unused kinds included
				if ($urandom_range(0, 19) == 0) r = any_request();
				add(r);
			end
			if ($urandom_range(0, 4) != 0) add(mk(REQ_REFRESH, $urandom(), $urandom(),
				$urandom(), $urandom()));
			repeat ($urandom_range(2, 8)) begin
				r = any_request();
				r.kind = REQ_READ;
				case ($urandom_range(0, 9))
					0: ;
					1, 2, 3, 4: begin
						ix = last_base + $urandom_range(0, 13) +
							($urandom_range(0, 1) ? SCREEN_WIDTH : 0);
						r.idx = 9'((ix < BUF_BYTES) ? ix : $urandom_range(0, BUF_BYTES - 1));
					end
					default: r.idx = 9'($urandom_range(0, BUF_BYTES - 1));
				endcase
				add(r);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_total < queued_total || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		$display("accepted %0d chars, %0d digits, %0d clears, %0d refreshes, %0d reads",
			kind_seen[REQ_CHAR], kind_seen[REQ_DIGIT], kind_seen[REQ_CLEAR],
			kind_seen[REQ_REFRESH], kind_seen[REQ_READ]);
		$display("plus %0d unused requests; %0d results checked, %0d mismatches",
			accepted_total - kind_seen[REQ_CHAR] - kind_seen[REQ_DIGIT] - kind_seen[REQ_CLEAR]
			- kind_seen[REQ_REFRESH] - kind_seen[REQ_READ], replies_checked, err_cnt);
		if (err_cnt == 0) begin
			$display("text_framebuffer_renderer_top_tb: done, clean");
		end else begin
			$display("text_framebuffer_renderer_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d of %0d transactions accepted, %0d results outstanding",
			accepted_total, queued_total, predicted_replies.size());
		$display("text_framebuffer_renderer_top_tb: done, errors");
		$finish;
	end

endmodule
